FILE: rtl/quad_zone_point_test_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadrilateral zone test
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUAD_ZONE_POINT_TEST_ASSERT_SVH
`define QUAD_ZONE_POINT_TEST_ASSERT_SVH

// Same-cycle implication.
`define QZPT_CHECK(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
	else $error(msg);

// Next-cycle implication.
`define QZPT_CHECK_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
	else $error(msg);

`endif

FILE: rtl/qzpt_pkg.sv
// ----------------------------------------------------------------------------
// qzpt_pkg
// Shared types, table layout and defaults of the quadrilateral zone test.
// ----------------------------------------------------------------------------
package qzpt_pkg;

	// Defaults for the top level parameters
	localparam int DEF_NUM_ZONES  = 8;
	localparam int DEF_NUM_FLAGS  = 8;
	localparam int DEF_COORD_BITS = 32;

	// Request field widths
	localparam int FIELD_W     = 32;
	localparam int ZONE_IDX_W  = 3;
	localparam int WORD_ADDR_W = 5;
	localparam int SLOT_W      = 3;

	// Zone table layout, in words
	localparam int ZONE_WORDS     = 32;
	localparam int PICKUP_BASE    = 0;
	localparam int DROPOUT_BASE   = 8;
	localparam int SEC_BASE       = 16;
	localparam int SEC_WORDS      = ZONE_WORDS - SEC_BASE;
	localparam int SEC_PAIR_WORDS = 4;   // lo.x, lo.y, hi.x, hi.y

	// Vertex codes, in table order
	localparam int NUM_VERTS = 4;
	localparam int VTX_A     = 0;
	localparam int VTX_B     = 1;
	localparam int VTX_C     = 2;
	localparam int VTX_D     = 3;

	// Vertex sets
	localparam int NUM_SETS    = 2;
	localparam int SET_PICKUP  = 0;
	localparam int SET_DROPOUT = 1;

	// Sector pairs in table order: n34/n32, n12/n14, n41/n43, n23/n21
	localparam int SEC_PAIR_C = 0;
	localparam int SEC_PAIR_A = 1;
	localparam int SEC_PAIR_D = 2;
	localparam int SEC_PAIR_B = 3;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_EVAL  = 1'b1
	} req_type_t;

	typedef struct packed {
		logic              ok;     // zone and flag slot both in range
		logic [SLOT_W-1:0] slot;
	} meta_t;

	typedef struct packed {
		logic  hit_pu;   // verdict against the pickup quadrilateral
		logic  hit_do;   // verdict against the dropout quadrilateral
		meta_t meta;
	} verdict_t;

	// Word holding the x coordinate of vertex k of a set; y follows it.
	function automatic int unsigned vtx_word(input int unsigned set, input int unsigned k);
		return ((set == SET_DROPOUT) ? DROPOUT_BASE : PICKUP_BASE) + 2 * k;
	endfunction

	// Offset inside the sector block of the lower bound vector of vertex k.
	function automatic int unsigned sec_lo_off(input int unsigned k);
		int unsigned pair;
		unique case (k)
			VTX_A:   pair = SEC_PAIR_A;
			VTX_B:   pair = SEC_PAIR_B;
			VTX_C:   pair = SEC_PAIR_C;
			VTX_D:   pair = SEC_PAIR_D;
			default: pair = SEC_PAIR_C;
		endcase
		return pair * SEC_PAIR_WORDS;
	endfunction

endpackage

FILE: rtl/qzpt_chan_if.sv
// ----------------------------------------------------------------------------
// qzpt_chan_if
// Valid/ready channels for zone requests and zone verdicts.
// ----------------------------------------------------------------------------
interface qzpt_req_if
	import qzpt_pkg::*;
();
	logic                       valid;
	logic                       ready;
	req_type_t                  req_type;
	logic [ZONE_IDX_W-1:0]      zone_index;
	logic [WORD_ADDR_W-1:0]     word_addr;
	logic signed [FIELD_W-1:0]  word_data;
	logic [SLOT_W-1:0]          flag_slot;
	logic signed [FIELD_W-1:0]  point_x;
	logic signed [FIELD_W-1:0]  point_y;

	modport source (
		output valid, req_type, zone_index, word_addr, word_data, flag_slot,
		       point_x, point_y,
		input  ready
	);
	modport sink (
		input  valid, req_type, zone_index, word_addr, word_data, flag_slot,
		       point_x, point_y,
		output ready
	);
endinterface

interface qzpt_res_if
	import qzpt_pkg::*;
();
	logic valid;
	logic ready;
	logic in_zone;

	modport source (output valid, in_zone, input ready);
	modport sink (input valid, in_zone, output ready);
endinterface

FILE: rtl/quad_zone_point_test.sv
// ----------------------------------------------------------------------------
// quad_zone_point_test: quadrilateral relay zone test with hysteresis
// An evaluate request goes through stages s1 to s5 and the result register.
// One request per cycle when not stalled; write requests give no verdict.
// Reset clears the hysteresis flags and all stage valids; the table is kept.
// ----------------------------------------------------------------------------
module quad_zone_point_test
	import qzpt_pkg::*;
#(
	parameter int NUM_ZONES  = DEF_NUM_ZONES,
	parameter int NUM_FLAGS  = DEF_NUM_FLAGS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	qzpt_req_if.sink   req,
	qzpt_res_if.source rsp
);
	// Pipeline map
	//   s1  table row read (registered memory output) and request capture;
	//       write requests update the table here and go no further
	//   s2  point minus vertex for all eight vertices, pickup and dropout
	//   s3  squared components and sector cross products (one multiply deep)
	//   s4  squared lengths and per-vertex sector tests
	//   s5  minimum-length diagonal choice and verdict for each vertex set
	//   out the stored flag picks the set, the verdict updates the flag and
	//       lands in the result register
	// Both vertex sets are carried to the end so that the flag is read and
	// written in the same stage; no hazard between requests on one slot.
	// Each stage has its own valid and accepts whenever it is empty or its
	// successor moves, so bubbles collapse while the result waits.

	logic            v_s1;
	meta_t           meta_s1;
	logic [ZONE_WORDS-1:0][COORD_BITS-1:0] row_s1;
	logic signed [COORD_BITS-1:0] px_s1;
	logic signed [COORD_BITS-1:0] py_s1;
	logic            geom_ready;

	logic            v_s5;
	verdict_t        res_s5;
	logic            decide_ready;

	// Intake and zone table
	qzpt_fetch #(
		.NUM_ZONES  (NUM_ZONES),
		.NUM_FLAGS  (NUM_FLAGS),
		.COORD_BITS (COORD_BITS)
	) u_fetch (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.dn_ready (geom_ready),
		.v_s1     (v_s1),
		.meta_s1  (meta_s1),
		.row_s1   (row_s1),
		.px_s1    (px_s1),
		.py_s1    (py_s1)
	);

	// Geometry for both vertex sets
	qzpt_geom #(
		.COORD_BITS (COORD_BITS)
	) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s1),
		.up_ready (geom_ready),
		.up_meta  (meta_s1),
		.up_row   (row_s1),
		.up_px    (px_s1),
		.up_py    (py_s1),
		.v_s5     (v_s5),
		.res_s5   (res_s5),
		.dn_ready (decide_ready)
	);

	// Hysteresis and result register
	qzpt_decide #(
		.NUM_FLAGS (NUM_FLAGS)
	) u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s5),
		.up_ready (decide_ready),
		.up_res   (res_s5),
		.rsp      (rsp)
	);

endmodule

FILE: rtl/qzpt_fetch.sv
// ----------------------------------------------------------------------------
// qzpt_fetch
// Request intake, zone table storage and registered row read.
// ----------------------------------------------------------------------------
`include "quad_zone_point_test_assert.svh"

module qzpt_fetch
	import qzpt_pkg::*;
#(
	parameter int NUM_ZONES  = DEF_NUM_ZONES,
	parameter int NUM_FLAGS  = DEF_NUM_FLAGS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	qzpt_req_if.sink                              req,
	input  logic                                  dn_ready,
	output logic                                  v_s1,
	output meta_t                                 meta_s1,
	output logic [ZONE_WORDS-1:0][COORD_BITS-1:0] row_s1,
	output logic signed [COORD_BITS-1:0]          px_s1,
	output logic signed [COORD_BITS-1:0]          py_s1
);
	localparam int ZA      = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
	localparam int IDX_PAD = 8;

	// One row per zone, written a word at a time
	logic [ZONE_WORDS-1:0][COORD_BITS-1:0] mem_q [NUM_ZONES];

	logic [IDX_PAD-1:0] zone_ext;
	logic [ZA-1:0]      zone_addr;
	logic               zone_ok;
	logic               slot_ok;
	logic               rdy;
	logic               take;
	logic               is_eval;

	assign zone_ext  = IDX_PAD'(req.zone_index);
	assign zone_addr = zone_ext[ZA-1:0];
	assign zone_ok   = int'(req.zone_index) < NUM_ZONES;
	assign slot_ok   = int'(req.flag_slot) < NUM_FLAGS;
	assign is_eval   = req.req_type == REQ_EVAL;

	assign rdy       = !v_s1 || dn_ready;
	assign req.ready = rdy;
	assign take      = req.valid && rdy;

	always_ff @(posedge clk) begin
		if (take && !is_eval && zone_ok) begin
			mem_q[zone_addr][req.word_addr] <= req.word_data[COORD_BITS-1:0];
		end
		if (take && is_eval) begin
			row_s1  <= mem_q[zone_addr];
			meta_s1 <= '{ok: zone_ok && slot_ok, slot: req.flag_slot};
			px_s1   <= req.point_x[COORD_BITS-1:0];
			py_s1   <= req.point_y[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy) begin
			v_s1 <= take && is_eval;
		end
	end

	`QZPT_CHECK_NEXT(a_s1_hold, v_s1 && !dn_ready,
		v_s1 && $stable(meta_s1) && $stable(px_s1) && $stable(py_s1),
		"stalled stage 1 request changed")

endmodule

FILE: rtl/qzpt_geom.sv
// ----------------------------------------------------------------------------
// qzpt_geom
// Offsets, squared lengths, cross products and diagonal choice for both sets.
// ----------------------------------------------------------------------------
`include "quad_zone_point_test_assert.svh"

module qzpt_geom
	import qzpt_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  up_valid,
	output logic                                  up_ready,
	input  meta_t                                 up_meta,
	input  logic [ZONE_WORDS-1:0][COORD_BITS-1:0] up_row,
	input  logic signed [COORD_BITS-1:0]          up_px,
	input  logic signed [COORD_BITS-1:0]          up_py,
	output logic                                  v_s5,
	output verdict_t                              res_s5,
	input  logic                                  dn_ready
);
	localparam int C     = COORD_BITS;
	localparam int DW    = C + 1;       // point minus vertex
	localparam int SQW   = 2 * C;       // one squared component
	localparam int LW    = 2 * C + 1;   // squared length, cross product
	localparam int TERMS = 4;           // z.y*lo.x, z.x*lo.y, z.y*hi.x, z.x*hi.y

	logic v_s2, v_s3, v_s4;
	logic rdy2, rdy3, rdy4, rdy5;
	meta_t meta_s2, meta_s3, meta_s4;

	logic signed [DW-1:0]     dx_s2   [NUM_SETS][NUM_VERTS];
	logic signed [DW-1:0]     dy_s2   [NUM_SETS][NUM_VERTS];
	logic [SEC_WORDS-1:0][C-1:0] secv_s2;

	logic signed [LW-1:0]     sqx_c   [NUM_SETS][NUM_VERTS];
	logic signed [LW-1:0]     sqy_c   [NUM_SETS][NUM_VERTS];
	logic signed [LW-1:0]     cp_c    [NUM_SETS][NUM_VERTS][TERMS];
	logic [SQW-1:0]           sqx_s3  [NUM_SETS][NUM_VERTS];
	logic [SQW-1:0]           sqy_s3  [NUM_SETS][NUM_VERTS];
	logic signed [LW-1:0]     cp_s3   [NUM_SETS][NUM_VERTS][TERMS];

	logic [LW-1:0]            len_s4  [NUM_SETS][NUM_VERTS];
	logic [NUM_VERTS-1:0]     sec_s4  [NUM_SETS];

	logic [LW-1:0]            near_c  [NUM_SETS];
	logic [NUM_SETS-1:0]      use_bd_c;
	logic [NUM_SETS-1:0]      hit_c;

	function automatic logic signed [DW-1:0] ext1(input logic [C-1:0] v);
		return $signed({v[C-1], v});
	endfunction

	// Each stage moves when empty or when the next one moves
	assign rdy5     = !v_s5 || dn_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign up_ready = rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy2) v_s2 <= up_valid;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Products of stage 3
	always_comb begin
		for (int s = 0; s < NUM_SETS; s++) begin
			for (int k = 0; k < NUM_VERTS; k++) begin
				sqx_c[s][k]   = LW'(dx_s2[s][k]) * LW'(dx_s2[s][k]);
				sqy_c[s][k]   = LW'(dy_s2[s][k]) * LW'(dy_s2[s][k]);
				cp_c[s][k][0] = LW'(dy_s2[s][k]) * LW'($signed(secv_s2[sec_lo_off(k)]));
				cp_c[s][k][1] = LW'(dx_s2[s][k]) * LW'($signed(secv_s2[sec_lo_off(k) + 1]));
				cp_c[s][k][2] = LW'(dy_s2[s][k]) * LW'($signed(secv_s2[sec_lo_off(k) + 2]));
				cp_c[s][k][3] = LW'(dx_s2[s][k]) * LW'($signed(secv_s2[sec_lo_off(k) + 3]));
			end
		end
	end

	// Minimum-length rule picks the diagonal pair per set
	always_comb begin
		for (int s = 0; s < NUM_SETS; s++) begin
			near_c[s]   = (len_s4[s][VTX_A] < len_s4[s][VTX_C]) ?
			              len_s4[s][VTX_A] : len_s4[s][VTX_C];
			use_bd_c[s] = (near_c[s] < len_s4[s][VTX_B]) && (near_c[s] < len_s4[s][VTX_D]);
			hit_c[s]    = use_bd_c[s] ? (sec_s4[s][VTX_D] && sec_s4[s][VTX_B])
			                          : (sec_s4[s][VTX_C] && sec_s4[s][VTX_A]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && up_valid) begin
			meta_s2 <= up_meta;
			secv_s2 <= up_row[ZONE_WORDS-1:SEC_BASE];
			for (int s = 0; s < NUM_SETS; s++) begin
				for (int k = 0; k < NUM_VERTS; k++) begin
					dx_s2[s][k] <= ext1(up_px) - ext1(up_row[vtx_word(s, k)]);
					dy_s2[s][k] <= ext1(up_py) - ext1(up_row[vtx_word(s, k) + 1]);
				end
			end
		end
		if (rdy3 && v_s2) begin
			meta_s3 <= meta_s2;
			for (int s = 0; s < NUM_SETS; s++) begin
				for (int k = 0; k < NUM_VERTS; k++) begin
					sqx_s3[s][k] <= sqx_c[s][k][SQW-1:0];
					sqy_s3[s][k] <= sqy_c[s][k][SQW-1:0];
					for (int t = 0; t < TERMS; t++) begin
						cp_s3[s][k][t] <= cp_c[s][k][t];
					end
				end
			end
		end
		if (rdy4 && v_s3) begin
			meta_s4 <= meta_s3;
			for (int s = 0; s < NUM_SETS; s++) begin
				for (int k = 0; k < NUM_VERTS; k++) begin
					len_s4[s][k] <= {1'b0, sqx_s3[s][k]} + {1'b0, sqy_s3[s][k]};
					// strictly ccw of lo and strictly cw of hi
					sec_s4[s][k] <= (cp_s3[s][k][0] > cp_s3[s][k][1]) &&
					                (cp_s3[s][k][2] < cp_s3[s][k][3]);
				end
			end
		end
		if (rdy5 && v_s4) begin
			res_s5 <= '{hit_pu: hit_c[SET_PICKUP], hit_do: hit_c[SET_DROPOUT], meta: meta_s4};
		end
	end

	`QZPT_CHECK(a_ready_chain, v_s2 && !v_s3, up_ready,
		"stage 2 blocked with stage 3 empty")
	`QZPT_CHECK_NEXT(a_s5_hold, v_s5 && !dn_ready, v_s5 && $stable(res_s5),
		"stalled stage 5 verdict changed")

endmodule

FILE: rtl/qzpt_decide.sv
// ----------------------------------------------------------------------------
// qzpt_decide
// Hysteresis flags, final verdict and result register.
// ----------------------------------------------------------------------------
`include "quad_zone_point_test_assert.svh"

module qzpt_decide
	import qzpt_pkg::*;
#(
	parameter int NUM_FLAGS = DEF_NUM_FLAGS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        up_valid,
	output logic        up_ready,
	input  verdict_t    up_res,
	qzpt_res_if.source  rsp
);
	localparam int FA      = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;
	localparam int IDX_PAD = 8;

	logic [NUM_FLAGS-1:0] flags_q;
	logic                 out_valid_q;
	logic                 in_zone_q;
	logic                 fire;
	logic                 flag_cur;
	logic                 hit_c;
	logic [IDX_PAD-1:0]   slot_ext;
	logic [FA-1:0]        slot_idx;

	assign up_ready = !out_valid_q || rsp.ready;
	assign fire     = up_valid && up_ready;
	assign slot_ext = IDX_PAD'(up_res.meta.slot);
	assign slot_idx = slot_ext[FA-1:0];

	// Flag read and write sit in this stage, so back-to-back requests on
	// one slot see each other in order.
	assign flag_cur = flags_q[slot_idx];
	assign hit_c    = up_res.meta.ok && (flag_cur ? up_res.hit_do : up_res.hit_pu);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			out_valid_q <= 1'b0;
			in_zone_q   <= 1'b0;
		end else begin
			if (up_ready) out_valid_q <= up_valid;
			if (fire) begin
				in_zone_q <= hit_c;
				if (up_res.meta.ok) flags_q[slot_idx] <= hit_c;
			end
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.in_zone = in_zone_q;

	`QZPT_CHECK_NEXT(a_flag_quiet, !fire, $stable(flags_q),
		"flag changed without a verdict")
	`QZPT_CHECK_NEXT(a_bad_zero, fire && !up_res.meta.ok, out_valid_q && !in_zone_q,
		"out of range request gave a hit")

endmodule
